### design/kc3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_pkg - shared types and constants for the 3x3 convolution filter
// Pixel and partial-sum types, fixed-point widths, register indexes and the
// coefficient lookup used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package kc3_pkg;

   localparam int PIX_BITS      = 8;
   localparam int COEF_BITS     = 16;
   localparam int SUM_BITS      = 29;   // nine Q4.12 x 8-bit products
   localparam int GAIN_BITS     = 16;
   localparam int BIAS_BITS     = 9;
   localparam int PROD_BITS     = SUM_BITS + GAIN_BITS;
   localparam int FRAC_BITS     = 20;
   localparam int TAPS          = 9;
   localparam int TAP_IDX_BITS  = 4;
   localparam int FW_BITS       = 11;
   localparam int FH_BITS       = 13;
   localparam int ROW_BITS      = 12;
   localparam int MAX_HEIGHT    = 4096;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam logic [PIX_BITS-1:0] CH_MAX = 8'hFF;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_COEF_WORD_0  = 3'd2,
      CSR_COEF_WORD_1  = 3'd3,
      CSR_COEF_WORD_2  = 3'd4,
      CSR_GAIN         = 3'd5,
      CSR_BIAS         = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] red;
   } pix_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] blue;
      logic signed [SUM_BITS-1:0] green;
      logic signed [SUM_BITS-1:0] red;
   } sum_type;

   // tap t sits in word t/4 at bits 16*(t%4)
   function automatic logic signed [COEF_BITS-1:0] coef_of(
      input logic [CSR_DATA_BITS-1:0] w0,
      input logic [CSR_DATA_BITS-1:0] w1,
      input logic [CSR_DATA_BITS-1:0] w2,
      input logic [TAP_IDX_BITS-1:0]  t
   );
      logic [CSR_DATA_BITS-1:0] w;
      begin
         if (t < 4'd4) begin
            w = w0;
         end else if (t < 4'd8) begin
            w = w1;
         end else begin
            w = w2;
         end
         coef_of = w[16*t[1:0] +: COEF_BITS];
      end
   endfunction

endpackage

### design/kc3_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_cell - one tap cell of the convolution chain
// Holds one gathered tap, passes it on when the chain shifts, and adds its
// weighted tap to the partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module kc3_cell (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  kc3_pkg::pix_type                      tap_in,
   input  logic signed [kc3_pkg::COEF_BITS-1:0]  coef,
   input  kc3_pkg::sum_type                      sum_in,
   output kc3_pkg::pix_type                      tap_out,
   output kc3_pkg::sum_type                      sum_out
);

   localparam int MUL_BITS = kc3_pkg::COEF_BITS + kc3_pkg::PIX_BITS + 1;

   kc3_pkg::pix_type tap_ff;
   kc3_pkg::sum_type sum_ff;
   kc3_pkg::sum_type sum_in_w;
   logic signed [MUL_BITS-1:0] mul_r, mul_g, mul_b;

   always_comb begin
      mul_r = coef * $signed({1'b0, tap_ff.red});
      mul_g = coef * $signed({1'b0, tap_ff.green});
      mul_b = coef * $signed({1'b0, tap_ff.blue});
      sum_in_w.red   = sum_in.red   + kc3_pkg::SUM_BITS'(mul_r);
      sum_in_w.green = sum_in.green + kc3_pkg::SUM_BITS'(mul_g);
      sum_in_w.blue  = sum_in.blue  + kc3_pkg::SUM_BITS'(mul_b);
   end

   // advance the tap only on a shift; the sum ripples every cycle
   always_ff @(posedge clock) begin
      if (shift_en) begin
         tap_ff <= tap_in;
      end
      sum_ff <= sum_in_w;
   end

   assign tap_out = tap_ff;
   assign sum_out = sum_ff;

endmodule

### design/kernel_convolution_3x3_top.sv
`timescale 1ns / 1ps
// Taking an item that releases a result raises req_stall through the nine-read sweep
//   of the line store, the nine-cell sum chain and the scaling, until the result is
//   loaded into the output; taking an item that releases no result never stalls.
// Reset (synchronous, active high): clears positions, counts and the output
//   item; registers return to width 1024, height 1024, identity kernel, gain
//   1.0, no bias. The line store holds no reset; its taps are used only once written.
// ----------------------------------------------------------------------------
// kernel_convolution_3x3_top - 3x3 RGB convolution filter, top level
// Stores incoming pixels in a ring, gathers the nine taps of each pending
// output through a chain of tap cells, scales, biases and clamps the sums.
// ----------------------------------------------------------------------------
module kernel_convolution_3x3_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic [kc3_pkg::PIX_BITS-1:0]           req_red,
   input  logic [kc3_pkg::PIX_BITS-1:0]           req_green,
   input  logic [kc3_pkg::PIX_BITS-1:0]           req_blue,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [kc3_pkg::PIX_BITS-1:0]           rsp_out_red,
   output logic [kc3_pkg::PIX_BITS-1:0]           rsp_out_green,
   output logic [kc3_pkg::PIX_BITS-1:0]           rsp_out_blue,
   output logic [kc3_pkg::PIX_BITS-1:0]           rsp_out_alpha,
   output logic                                   rsp_frame_end,
   // register writes
   input  logic                                   csr_wr_en,
   input  logic [kc3_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [kc3_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int DEPTH = 2 * MAX_WIDTH + 4;     // ring of recent pixels
   localparam int AW    = $clog2(DEPTH);
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int SW    = AW + 2;                 // signed address arithmetic

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_GATHER = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_SCALE  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic signed [kc3_pkg::PROD_BITS-1:0] blue;
      logic signed [kc3_pkg::PROD_BITS-1:0] green;
      logic signed [kc3_pkg::PROD_BITS-1:0] red;
   } prod_type;

   // ---------------------------------------------------------------- registers
   logic [kc3_pkg::FW_BITS-1:0]              fw_ff;
   logic [kc3_pkg::FH_BITS-1:0]              fh_ff;
   logic [kc3_pkg::CSR_DATA_BITS-1:0]        cw0_ff, cw1_ff, cw2_ff;
   logic signed [kc3_pkg::GAIN_BITS-1:0]     gain_ff;
   logic signed [kc3_pkg::BIAS_BITS-1:0]     bias_ff;
   logic                                     restart;

   assign restart = csr_wr_en &&
                    (csr_index == kc3_pkg::CSR_FRAME_WIDTH ||
                     csr_index == kc3_pkg::CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= kc3_pkg::FW_BITS'(1024);
         fh_ff   <= kc3_pkg::FH_BITS'(1024);
         cw0_ff  <= '0;
         cw1_ff  <= kc3_pkg::CSR_DATA_BITS'(4096);
         cw2_ff  <= '0;
         gain_ff <= kc3_pkg::GAIN_BITS'(256);
         bias_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            kc3_pkg::CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata[kc3_pkg::FW_BITS-1:0];
            kc3_pkg::CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata[kc3_pkg::FH_BITS-1:0];
            kc3_pkg::CSR_COEF_WORD_0:  cw0_ff  <= csr_wdata;
            kc3_pkg::CSR_COEF_WORD_1:  cw1_ff  <= csr_wdata;
            kc3_pkg::CSR_COEF_WORD_2:  cw2_ff  <= csr_wdata;
            kc3_pkg::CSR_GAIN:         gain_ff <= csr_wdata[kc3_pkg::GAIN_BITS-1:0];
            kc3_pkg::CSR_BIAS:         bias_ff <= csr_wdata[kc3_pkg::BIAS_BITS-1:0];
            default: ;                 // unmapped index: drop
         endcase
      end
   end

   // Effective frame size: zero counts as one, oversize clamps to the limit.
   logic [WB-1:0]               ew;
   logic [kc3_pkg::FH_BITS-1:0] eh;

   always_comb begin
      if (fw_ff == '0) begin
         ew = WB'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         ew = WB'(MAX_WIDTH);
      end else begin
         ew = WB'(fw_ff);
      end
      if (fh_ff == '0) begin
         eh = kc3_pkg::FH_BITS'(1);
      end else if (32'(fh_ff) > kc3_pkg::MAX_HEIGHT) begin
         eh = kc3_pkg::FH_BITS'(kc3_pkg::MAX_HEIGHT);
      end else begin
         eh = fh_ff;
      end
   end

   // ---------------------------------------------------------------- control
   state_type                     state_ff, state_in;
   logic [AW-1:0]                 in_ptr_ff, out_ptr_ff;
   logic [AW-1:0]                 pend_ff;        // pixels taken, not yet emitted
   logic [WB-1:0]                 out_col_ff;
   logic [kc3_pkg::ROW_BITS-1:0]  out_row_ff;
   logic [1:0]                    dx_ff, dy_ff;
   logic [kc3_pkg::TAP_IDX_BITS-1:0] sum_cnt_ff;
   logic                          rd_en_ff, mask_ff;
   kc3_pkg::pix_type              rd_data_ff;
   prod_type                      prod_ff;

   logic req_acc, pix_acc, emit_go, out_load;
   logic col_last, row_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign pix_acc   = req_acc && !req_op;

   // a pixel releases a result once a row plus one pixel is already pending
   assign emit_go = req_op ? (pend_ff != '0) : (32'(pend_ff) >= 32'(ew) + 32'd1);

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid || !rsp_stall);
   assign col_last = (32'(out_col_ff) == 32'(ew) - 32'd1);
   assign row_last = (32'(out_row_ff) == 32'(eh) - 32'd1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc && emit_go) state_in = ST_GATHER;
         ST_GATHER: if (dx_ff == 2'd2 && dy_ff == 2'd2) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_SUM;
         ST_SUM:    if (sum_cnt_ff == kc3_pkg::TAP_IDX_BITS'(kc3_pkg::TAPS - 1))
                       state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DONE;
         ST_DONE:   if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- tap address
   // Offset of the tap from the output pixel in stream order, wrapped into
   // the ring with one correction either way.
   logic signed [SW-1:0] row_off, tap_off, addr_s;
   logic [AW-1:0]        rd_addr;
   logic                 tap_ok;

   always_comb begin
      case (dy_ff)
         2'd0:    row_off = -$signed(SW'(ew));
         2'd2:    row_off = $signed(SW'(ew));
         default: row_off = '0;
      endcase
      tap_off = row_off + $signed(SW'(dx_ff)) - $signed(SW'(1));
      addr_s  = $signed(SW'(out_ptr_ff)) + tap_off;
      if (addr_s < 0) begin
         addr_s = addr_s + $signed(SW'(DEPTH));
      end else if (addr_s >= $signed(SW'(DEPTH))) begin
         addr_s = addr_s - $signed(SW'(DEPTH));
      end
      rd_addr = addr_s[AW-1:0];
      // outside the frame, or not yet received: counts as zero
      tap_ok = (dx_ff != 2'd0 || out_col_ff != '0) &&
               (dx_ff != 2'd2 || !col_last) &&
               (dy_ff != 2'd0 || out_row_ff != '0) &&
               (dy_ff != 2'd2 || !row_last) &&
               (tap_off < $signed(SW'(pend_ff)));
   end

   // ---------------------------------------------------------------- line store
   kc3_pkg::pix_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         mem[in_ptr_ff] <= '{blue: req_blue, green: req_green, red: req_red};
      end
      rd_data_ff <= mem[rd_addr];
   end

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      begin
         ptr_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         in_ptr_ff  <= '0;
         out_ptr_ff <= '0;
         pend_ff    <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         dx_ff      <= '0;
         dy_ff      <= '0;
         sum_cnt_ff <= '0;
         rd_en_ff   <= 1'b0;
         mask_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_en_ff <= (state_ff == ST_GATHER);
         mask_ff  <= tap_ok;
         if (restart) begin
            // new frame geometry: drop everything pending
            in_ptr_ff  <= '0;
            out_ptr_ff <= '0;
            pend_ff    <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (pix_acc) begin
               in_ptr_ff <= ptr_next(in_ptr_ff);
               pend_ff   <= pend_ff + AW'(1);
            end
            if (out_load) begin
               out_ptr_ff <= ptr_next(out_ptr_ff);
               pend_ff    <= pend_ff - AW'(1);
               if (col_last) begin
                  out_col_ff <= '0;
                  out_row_ff <= row_last ? '0 : out_row_ff + kc3_pkg::ROW_BITS'(1);
               end else begin
                  out_col_ff <= out_col_ff + WB'(1);
               end
            end
         end
         // walk the window in raster order
         if (state_ff == ST_GATHER) begin
            if (dx_ff == 2'd2) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + 2'd1;
            end else begin
               dx_ff <= dx_ff + 2'd1;
            end
         end else begin
            dx_ff <= '0;
            dy_ff <= '0;
         end
         sum_cnt_ff <= (state_ff == ST_SUM) ? sum_cnt_ff + kc3_pkg::TAP_IDX_BITS'(1) : '0;
      end
   end

   // ---------------------------------------------------------------- cell chain
   // Taps enter at cell 0 in raster order, so cell k ends up with tap 8-k.
   kc3_pkg::pix_type tap_link [kc3_pkg::TAPS+1];
   kc3_pkg::sum_type sum_link [kc3_pkg::TAPS+1];

   assign tap_link[0] = mask_ff ? rd_data_ff : '0;
   assign sum_link[0] = '0;

   for (genvar k = 0; k < kc3_pkg::TAPS; k++) begin : g_cell
      kc3_cell u_cell (
         .clock    (clock),
         .shift_en (rd_en_ff),
         .tap_in   (tap_link[k]),
         .coef     (kc3_pkg::coef_of(cw0_ff, cw1_ff, cw2_ff,
                                     kc3_pkg::TAP_IDX_BITS'(kc3_pkg::TAPS - 1 - k))),
         .sum_in   (sum_link[k]),
         .tap_out  (tap_link[k+1]),
         .sum_out  (sum_link[k+1])
      );
   end

   // ---------------------------------------------------------------- scale
   kc3_pkg::sum_type acc;
   assign acc = sum_link[kc3_pkg::TAPS];

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         prod_ff.red   <= acc.red   * gain_ff;
         prod_ff.green <= acc.green * gain_ff;
         prod_ff.blue  <= acc.blue  * gain_ff;
      end
   end

   // add the bias once, floor, clamp to 0..255
   function automatic logic [kc3_pkg::PIX_BITS-1:0] clamp_ch(
      input logic signed [kc3_pkg::PROD_BITS-1:0] p,
      input logic signed [kc3_pkg::BIAS_BITS-1:0] b
   );
      logic signed [kc3_pkg::PROD_BITS:0] v;
      begin
         v = (kc3_pkg::PROD_BITS+1)'(p) +
             ((kc3_pkg::PROD_BITS+1)'(b) <<< kc3_pkg::FRAC_BITS);
         if (v < 0) begin
            clamp_ch = '0;
         end else if (|v[kc3_pkg::PROD_BITS:kc3_pkg::FRAC_BITS+kc3_pkg::PIX_BITS]) begin
            clamp_ch = kc3_pkg::CH_MAX;
         end else begin
            clamp_ch = v[kc3_pkg::FRAC_BITS +: kc3_pkg::PIX_BITS];
         end
      end
   endfunction

   // ---------------------------------------------------------------- output
   logic                          rsp_valid_ff;
   logic [kc3_pkg::PIX_BITS-1:0]  out_r_ff, out_g_ff, out_b_ff;
   logic                          frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_r_ff     <= clamp_ch(prod_ff.red,   bias_ff);
         out_g_ff     <= clamp_ch(prod_ff.green, bias_ff);
         out_b_ff     <= clamp_ch(prod_ff.blue,  bias_ff);
         frame_end_ff <= col_last && row_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_alpha = kc3_pkg::CH_MAX;
   assign rsp_frame_end = frame_end_ff;

endmodule

### design/kc3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_checker - port-level checks for the 3x3 convolution filter
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
module kc3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kc3_pkg::PIX_BITS-1:0]  rsp_out_red,
   input logic [kc3_pkg::PIX_BITS-1:0]  rsp_out_green,
   input logic [kc3_pkg::PIX_BITS-1:0]  rsp_out_blue,
   input logic [kc3_pkg::PIX_BITS-1:0]  rsp_out_alpha,
   input logic                          rsp_frame_end
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // alpha is always opaque
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_alpha == kc3_pkg::CH_MAX)
      else $error("alpha not opaque");

   // an item never produces its result in the very next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after an item was taken");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red) &&
         $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_frame_end))
      else $error("stalled result item changed");

endmodule

bind kernel_convolution_3x3_top kc3_checker u_kc3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_alpha (rsp_out_alpha),
   .rsp_frame_end (rsp_frame_end)
);
